[src/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VAL_W        = 32;
	localparam int POS_W        = 5;
	localparam int LEN_W        = 5;

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_INS_POS  = 3'd2,
		CMD_DEL_VAL  = 3'd3,
		CMD_DEL_POS  = 3'd4,
		CMD_DEL_ODD  = 3'd5,
		CMD_DUMP     = 3'd6,
		CMD_DUMP_REV = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_POS  = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL_AT,
		OP_DEL_MATCH,
		OP_ROT_L,
		OP_ROT_R
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_ODD,
		S_DUMP
	} state_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [VAL_W-1:0]  value;
	} cell_ctrl_t;

endpackage

[src/ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Requests arrive on the cmd channel (cmd_valid/cmd_stall) with command,
// value and position; results leave on the res channel (res_valid/res_stall)
// with status, element, has_element, length and last.
// One request is worked on at a time; cmd_stall is high while it runs.
// Inserts and deletes start in the accept cycle, which also latches every
// cell's compare against value; in the execute state, once the output register
// is free, the affected cells shift together and the result is loaded.
// Delete-odd removes one element per cycle through the cell chain, then
// loads its result once the output register is free.
// A dump rotates the chain by one cell per cycle and emits one result each
// cycle while the output register is free, with last on the final result.
// Results sit in an output register; while res_stall is high the result is
// held and the engine waits before loading the next one.
// Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module ordered_list_engine import ole_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  logic [2:0]              command,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] element,
	output logic                    has_element,
	output logic [LEN_W-1:0]        length,
	output logic                    last
);

	localparam int OW = $clog2(CAPACITY + 1);
	localparam int CW = ((OW > POS_W) ? OW : POS_W) + 1;
	localparam logic [OW-1:0] CAP_V = OW'(CAPACITY);

	state_t                  state_q, state_d;
	cmd_t                    cmd_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]        pos_q;
	logic [OW-1:0]           occ_q, occ_d;
	logic [OW-1:0]           k_q, k_d;

	logic                    res_valid_q;
	status_t                 status_q;
	logic signed [VAL_W-1:0] element_q;
	logic                    has_q;
	logic [LEN_W-1:0]        length_q;
	logic                    last_q;

	logic                    accept;
	logic                    can_emit;
	logic                    load;
	status_t                 r_status;
	logic signed [VAL_W-1:0] r_element;
	logic                    r_has;
	logic                    r_last;
	logic                    done;

	cell_ctrl_t              ctrl;
	logic [OW-1:0]           idx;
	logic signed [VAL_W-1:0] head;
	logic signed [VAL_W-1:0] tail;
	logic                    found;

	logic [CW-1:0]           pos_w;
	logic [CW-1:0]           occ_w;
	logic                    full;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign can_emit  = !res_valid_q || !res_stall;
	assign pos_w     = CW'(pos_q);
	assign occ_w     = CW'(occ_q);
	assign full      = (occ_q >= CAP_V);

	ole_chain #(
		.CAPACITY (CAPACITY),
		.OW       (OW)
	) u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.idx   (idx),
		.occ   (occ_q),
		.cap   (state_q == S_IDLE),
		.cmp   (value),
		.head  (head),
		.tail  (tail),
		.found (found)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command) inside
						CMD_DEL_ODD:               state_d = S_ODD;
						CMD_DUMP, CMD_DUMP_REV:    state_d = S_DUMP;
						default:                   state_d = S_EXEC;
					endcase
				end
			end
			S_EXEC, S_ODD, S_DUMP: begin
				if (done)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath controls and result
	always_comb begin
		ctrl      = '{op: OP_HOLD, value: val_q};
		idx       = '0;
		occ_d     = occ_q;
		k_d       = k_q;
		load      = 1'b0;
		done      = 1'b0;
		r_status  = ST_OK;
		r_element = '0;
		r_has     = 1'b0;
		r_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				k_d = '0;
			end
			S_EXEC: begin
				if (can_emit) begin
					load = 1'b1;
					done = 1'b1;
					case (cmd_q)
						CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
							if (full) begin
								r_status = ST_FULL;
							end else if (cmd_q == CMD_INS_HEAD) begin
								ctrl.op = OP_INS;
								occ_d   = occ_q + 1'b1;
							end else if (cmd_q == CMD_INS_TAIL) begin
								ctrl.op = OP_INS;
								idx     = occ_q;
								occ_d   = occ_q + 1'b1;
							end else if (pos_q == '0) begin
								if (occ_q != '0) begin
									ctrl.op = OP_INS;
									occ_d   = occ_q + 1'b1;
								end else begin
									r_status = ST_BAD_POS;
								end
							end else if (pos_w <= occ_w + 1'b1) begin
								ctrl.op = OP_INS;
								idx     = OW'(pos_w - 1'b1);
								occ_d   = occ_q + 1'b1;
							end else begin
								r_status = ST_BAD_POS;
							end
						end
						CMD_DEL_VAL: begin
							if (found) begin
								ctrl.op = OP_DEL_MATCH;
								occ_d   = occ_q - 1'b1;
							end else begin
								r_status = ST_NOTFOUND;
							end
						end
						CMD_DEL_POS: begin
							if (pos_q == '0 && occ_q != '0) begin
								ctrl.op = OP_DEL_AT;
								occ_d   = occ_q - 1'b1;
							end else if (pos_q != '0 && pos_w <= occ_w) begin
								ctrl.op = OP_DEL_AT;
								idx     = OW'(pos_w - 1'b1);
								occ_d   = occ_q - 1'b1;
							end else begin
								r_status = ST_BAD_POS;
							end
						end
						default: begin
							r_status = ST_OK;
						end
					endcase
				end
			end
			S_ODD: begin
				if (k_q < occ_q) begin
					ctrl.op = OP_DEL_AT;
					idx     = k_q;
					occ_d   = occ_q - 1'b1;
					k_d     = k_q + 1'b1;
				end else if (can_emit) begin
					load = 1'b1;
					done = 1'b1;
				end
			end
			S_DUMP: begin
				if (can_emit) begin
					load = 1'b1;
					if (occ_q == '0) begin
						done = 1'b1;
					end else begin
						r_has     = 1'b1;
						r_element = (cmd_q == CMD_DUMP) ? head : tail;
						ctrl.op   = (cmd_q == CMD_DUMP) ? OP_ROT_L : OP_ROT_R;
						k_d       = k_q + 1'b1;
						r_last    = (k_d == occ_q);
						done      = r_last;
					end
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			k_q     <= k_d;
			if (load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
			val_q <= value;
			pos_q <= position;
		end
		if (load) begin
			status_q  <= r_status;
			element_q <= r_element;
			has_q     <= r_has;
			length_q  <= LEN_W'(occ_d);
			last_q    <= r_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign element     = element_q;
	assign has_element = has_q;
	assign length      = length_q;
	assign last        = last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CAP_V)
		else $error("list count above capacity");

	a_idle_keeps_list: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_IDLE |-> occ_q == $past(occ_q))
		else $error("list count changed while idle");

	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_element |-> status == ST_OK)
		else $error("element result with error status");

	a_notlast_is_dump: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> has_element)
		else $error("non-final result without element");

endmodule

[src/ole_cell.sv]
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds an element and takes a neighbour's value on a shift.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; #(
	parameter int OW  = 5,
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic [OW-1:0]           idx,
	input  logic [OW-1:0]           occ,
	input  logic                    shift_sel,
	input  logic signed [VAL_W-1:0] left,
	input  logic signed [VAL_W-1:0] right,
	input  logic signed [VAL_W-1:0] head,
	input  logic signed [VAL_W-1:0] tail,
	input  logic signed [VAL_W-1:0] cmp,
	output logic signed [VAL_W-1:0] slot,
	output logic                    match,
	output logic signed [VAL_W-1:0] tail_part
);

	localparam logic [OW-1:0] MY_IDX  = OW'(IDX);
	localparam logic [OW-1:0] MY_NEXT = OW'(IDX + 1);

	logic signed [VAL_W-1:0] slot_q;
	logic signed [VAL_W-1:0] slot_d;
	logic                    is_tail;
	logic                    in_use;

	assign is_tail   = (MY_NEXT == occ);
	assign in_use    = (MY_IDX < occ);
	assign match     = in_use && (slot_q == cmp);
	assign tail_part = is_tail ? slot_q : '0;
	assign slot      = slot_q;

	always_comb begin
		slot_d = slot_q;
		case (ctrl.op)
			OP_INS: begin
				if (MY_IDX > idx)
					slot_d = left;
				else if (MY_IDX == idx)
					slot_d = ctrl.value;
			end
			OP_DEL_AT: begin
				if (MY_IDX >= idx)
					slot_d = right;
			end
			OP_DEL_MATCH: begin
				if (shift_sel)
					slot_d = right;
			end
			OP_ROT_L: begin
				slot_d = is_tail ? head : right;
			end
			OP_ROT_R: begin
				slot_d = (IDX == 0) ? tail : left;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

endmodule

[src/ole_chain.sv]
// ----------------------------------------------------------------------------
// ole_chain
// Row of list cells with neighbour links, match capture and head/tail taps.
// ----------------------------------------------------------------------------
module ole_chain import ole_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int OW       = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic [OW-1:0]           idx,
	input  logic [OW-1:0]           occ,
	input  logic                    cap,
	input  logic signed [VAL_W-1:0] cmp,
	output logic signed [VAL_W-1:0] head,
	output logic signed [VAL_W-1:0] tail,
	output logic                    found
);

	logic signed [VAL_W-1:0] slot      [CAPACITY];
	logic signed [VAL_W-1:0] tail_part [CAPACITY];
	logic [CAPACITY-1:0]     match;
	logic [CAPACITY-1:0]     match_q;
	logic [CAPACITY-1:0]     first;
	logic [CAPACITY-1:0]     ge;

	// match register taken while idle, consumed by the delete-value step
	always_ff @(posedge clk) begin
		if (cap)
			match_q <= match;
	end

	assign first = match_q & (~match_q + 1'b1);
	assign ge    = ~(first - 1'b1);
	assign found = |match_q;
	assign head  = slot[0];

	always_comb begin
		tail = '0;
		for (int i = 0; i < CAPACITY; i++)
			tail = tail | tail_part[i];
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = tail;
		end else begin : g_left
			assign left_v = slot[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = head;
		end else begin : g_right
			assign right_v = slot[i+1];
		end

		ole_cell #(
			.OW  (OW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (idx),
			.occ       (occ),
			.shift_sel (ge[i]),
			.left      (left_v),
			.right     (right_v),
			.head      (head),
			.tail      (tail),
			.cmp       (cmp),
			.slot      (slot[i]),
			.match     (match[i]),
			.tail_part (tail_part[i])
		);
	end

endmodule

[tb/ordered_list_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// Self-checking testbench for the ordered list engine.
// ----------------------------------------------------------------------------
// Requests go in one at a time through a shared send task. A behavioural
// copy of the list is updated on each accepted request and queues the
// results it should cause. A checker compares every accepted result, field
// by field, against the oldest queued result. Named tests cover the empty
// list, filling to capacity, the full and bad-position cases, a long
// result-side hold-off, a random mix and a final stream with no idling.
// ----------------------------------------------------------------------------
module ordered_list_engine_test;
	import ole_pkg::*;

	localparam int LIST_CAP = DEF_CAPACITY;

	typedef struct {
		status_t                  status;
		logic signed [VAL_W-1:0]  element;
		logic                     has_element;
		logic [LEN_W-1:0]         length;
		logic                     last;
	} list_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cmd_valid = 1'b0;
	logic                    cmd_stall;
	logic [2:0]              command = CMD_DUMP;
	logic signed [VAL_W-1:0] value = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] element;
	logic                    has_element;
	logic [LEN_W-1:0]        length;
	logic                    last;

	logic signed [VAL_W-1:0] list_model[$];
	list_result_t            pending_results[$];
	int                      mismatches = 0;
	bit                      sender_idling = 1'b1;
	bit                      receiver_idling = 1'b1;
	bit                      hold_results = 1'b0;
	bit                      hold_served = 1'b0;

	ordered_list_engine #(.CAPACITY(LIST_CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.command(command), .value(value), .position(position),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .element(element), .has_element(has_element),
		.length(length), .last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("ordered_list_engine_test: FAIL");
		$finish;
	end

	function automatic void queue_result(status_t st, logic signed [VAL_W-1:0] el,
			logic has, logic lst);
		list_result_t r;
		r.status      = st;
		r.element     = el;
		r.has_element = has;
		r.length      = LEN_W'(list_model.size());
		r.last        = lst;
		pending_results.push_back(r);
	endfunction

	function automatic status_t insert_element(int idx, logic signed [VAL_W-1:0] v);
		if (list_model.size() >= LIST_CAP)
			return ST_FULL;
		if (idx > list_model.size())
			return ST_BAD_POS;
		list_model.insert(idx, v);
		return ST_OK;
	endfunction

	// Updates the list copy for one accepted request and queues its results.
	function automatic void apply_list_request(cmd_t c, logic signed [VAL_W-1:0] v,
			logic [POS_W-1:0] p);
		status_t                 st;
		int                      n;
		int                      p_eff;
		logic signed [VAL_W-1:0] kept[$];
		st = ST_OK;
		n  = list_model.size();
		case (c)
			CMD_INS_HEAD: st = insert_element(0, v);
			CMD_INS_TAIL: st = insert_element(n, v);
			CMD_INS_POS: begin
				if (n >= LIST_CAP)
					st = ST_FULL;
				else if (p == 0)
					st = (n > 0) ? insert_element(0, v) : ST_BAD_POS;
				else
					st = insert_element(int'(p) - 1, v);
			end
			CMD_DEL_VAL: begin
				st = ST_NOTFOUND;
				for (int i = 0; i < n; i++) begin
					if (list_model[i] == v) begin
						list_model.delete(i);
						st = ST_OK;
						break;
					end
				end
			end
			CMD_DEL_POS: begin
				p_eff = (p == 0) ? 1 : int'(p);
				if (p_eff <= n)
					list_model.delete(p_eff - 1);
				else
					st = ST_BAD_POS;
			end
			CMD_DEL_ODD: begin
				for (int i = 1; i < n; i += 2)
					kept.push_back(list_model[i]);
				list_model = kept;
			end
			default: begin
				if (n == 0) begin
					queue_result(ST_OK, '0, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						queue_result(ST_OK, list_model[(c == CMD_DUMP) ? i : n - 1 - i],
							1'b1, i == n - 1);
				end
				return;
			end
		endcase
		queue_result(st, '0, 1'b0, 1'b1);
	endfunction

	task automatic send_request(cmd_t c, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= c;
		value     <= v;
		position  <= p;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		apply_list_request(c, v, p);
	endtask

	// Result side: random stall bursts, or a long counted hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_results && !hold_served) begin
				hold_served = 1'b1;
				res_stall <= 1'b1;
				repeat (80) @(posedge clk);
				res_stall <= 1'b0;
			end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d element %0d length %0d",
					status, element, length);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					mismatches++;
				end
				if (element !== exp_r.element) begin
					$error("element: expected %0d, got %0d", exp_r.element, element);
					mismatches++;
				end
				if (has_element !== exp_r.has_element) begin
					$error("has_element: expected %0d, got %0d",
						exp_r.has_element, has_element);
					mismatches++;
				end
				if (length !== exp_r.length) begin
					$error("length: expected %0d, got %0d", exp_r.length, length);
					mismatches++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, last);
					mismatches++;
				end
			end
		end
	end

	task automatic test_empty_list();
		send_request(CMD_DUMP, 32'sd7, 5'd0);
		send_request(CMD_DUMP_REV, -32'sd7, 5'd31);
		send_request(CMD_DEL_ODD, 32'sd0, 5'd0);
		send_request(CMD_DEL_VAL, 32'sd0, 5'd1);
		send_request(CMD_DEL_POS, 32'sd0, 5'd0);
		send_request(CMD_INS_POS, 32'sd9, 5'd0);
		send_request(CMD_INS_POS, 32'sd9, 5'd2);
		send_request(CMD_INS_POS, 32'sh7FFF_FFFF, 5'd1);
	endtask

	task automatic test_fill_to_capacity();
		logic signed [VAL_W-1:0] v;
		logic [POS_W-1:0]        p;
		for (int i = 0; i < LIST_CAP - 1; i++) begin
			v = (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sd0 : (i == 2) ? -32'sd1 :
				(i == 5 || i == 9) ? 32'sd42 : 32'(i * 123457 - 7);
			p = (i % 2) ? POS_W'(list_model.size() + 1) : POS_W'(list_model.size() / 2);
			send_request(cmd_t'(i % 3), v, p);
		end
		send_request(CMD_INS_HEAD, 32'sd1, 5'd1);
		send_request(CMD_INS_TAIL, 32'sd1, 5'd1);
		send_request(CMD_INS_POS, 32'sd1, 5'd31);
		send_request(CMD_DUMP, 32'sd0, 5'd0);
		send_request(CMD_DUMP_REV, 32'sd0, 5'd0);
	endtask

	task automatic test_update_edge_cases();
		send_request(CMD_DEL_POS, 32'sd0, 5'd31);
		send_request(CMD_DEL_POS, 32'sd0, 5'd0);
		send_request(CMD_DEL_VAL, 32'sd42, 5'd0);
		send_request(CMD_DEL_VAL, 32'sd12345, 5'd0);
		send_request(CMD_DEL_ODD, 32'sd0, 5'd0);
		send_request(CMD_INS_POS, 32'sd3, POS_W'(list_model.size() + 2));
		send_request(CMD_DUMP, 32'sd0, 5'd0);
	endtask

	// Results held back for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		hold_results = 1'b1;
		for (int i = 0; i < 20; i++)
			send_request((i % 4 == 3) ? CMD_DUMP_REV : cmd_t'(i % 2),
				$urandom, POS_W'($urandom_range(0, 31)));
	endtask

	function automatic cmd_t pick_command();
		int r;
		int ins_pct;
		ins_pct = (list_model.size() < 10) ? 60 : 35;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return cmd_t'($urandom_range(0, 2));
		if (r < 85)
			return ($urandom_range(0, 1)) ? CMD_DEL_VAL : CMD_DEL_POS;
		if (r < 89)
			return CMD_DEL_ODD;
		return ($urandom_range(0, 1)) ? CMD_DUMP : CMD_DUMP_REV;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35 && list_model.size() > 0)
			return list_model[$urandom_range(0, list_model.size() - 1)];
		if (r < 55) begin
			case ($urandom_range(0, 4))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return -32'sd1;
				3: return 32'sd0;
				default: return 32'($urandom_range(1, 9));
			endcase
		end
		return $urandom;
	endfunction

	task automatic test_random_mix(int n_requests);
		logic [POS_W-1:0] p;
		for (int i = 0; i < n_requests; i++) begin
			sender_idling   = (i % 50) >= 10;
			receiver_idling = ((i + 25) % 50) >= 10;
			p = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, list_model.size() + 1))
				: POS_W'($urandom_range(0, 31));
			send_request(pick_command(), pick_value(), p);
		end
	endtask

	task automatic test_steady_stream(int n_requests);
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		for (int i = 0; i < n_requests; i++)
			send_request(pick_command(), pick_value(),
				POS_W'($urandom_range(0, list_model.size() + 1)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_to_capacity();
		test_update_edge_cases();
		test_output_backpressure();
		test_random_mix(220);
		test_steady_stream(40);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("ordered_list_engine_test: PASS");
		else
			$display("ordered_list_engine_test: FAIL");
		$finish;
	end

endmodule

[filelist.f]
src/ole_pkg.sv
src/ole_cell.sv
src/ole_chain.sv
src/ordered_list_engine.sv
tb/ordered_list_engine_test.sv
